// ===== hdl/trrs_pkg.sv =====
// Shared types and constants for the two-level round-robin task scheduler.
`timescale 1ns / 1ps
package trrs_pkg;

   localparam int TASK_COUNT_DEF = 16;
   localparam logic [7:0] SLICE_RESET = 8'd10;

   // commands
   localparam logic [2:0] CMD_ADD   = 3'd0;
   localparam logic [2:0] CMD_WAKE  = 3'd1;
   localparam logic [2:0] CMD_TICK  = 3'd2;
   localparam logic [2:0] CMD_SCHED = 3'd3;
   localparam logic [2:0] CMD_SLEEP = 3'd4;
   localparam logic [2:0] CMD_BLOCK = 3'd5;
   localparam logic [2:0] CMD_EXIT  = 3'd6;

   // task states
   typedef logic [2:0] tstate_type;
   localparam tstate_type ST_FREE     = 3'd0;
   localparam tstate_type ST_READY    = 3'd1;
   localparam tstate_type ST_RUNNING  = 3'd2;
   localparam tstate_type ST_BLOCKED  = 3'd3;
   localparam tstate_type ST_SLEEPING = 3'd4;
   localparam tstate_type ST_DEAD     = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_ADD   = 3'd1,
      OP_READY = 3'd2,
      OP_STATE = 3'd3,
      OP_SLEEP = 3'd4,
      OP_EXIT  = 3'd5
   } cell_op_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type op;
      logic [7:0]  id;
      logic [3:0]  prio;
      tstate_type  state;
      logic [31:0] wake;
   } cell_cmd_type;

   typedef struct packed {
      tstate_type state;
      logic [3:0] prio;
   } cell_stat_type;

endpackage

// ===== hdl/trrs_cell.sv =====
// One task cell: state, priority, wake time and sleep flags of one task.
`timescale 1ns / 1ps
module trrs_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  trrs_pkg::cell_cmd_type cmd,
   input  logic [31:0]           tick,
   input  logic                  tok_in,
   output logic                  tok_out,
   output trrs_pkg::cell_stat_type stat,
   output logic                  hit
);

   trrs_pkg::tstate_type state_ff, state_in;
   logic [3:0]  prio_ff, prio_in;
   logic [31:0] wake_ff, wake_in;
   logic        listed_ff, listed_in;
   logic        tmo_ff, tmo_in;
   logic        tok_ff;
   logic        sel;
   logic [31:0] diff;

   assign sel  = (cmd.id == 8'(INDEX));
   assign diff = tick - wake_ff;

   always_comb begin
      state_in  = state_ff;
      prio_in   = prio_ff;
      wake_in   = wake_ff;
      listed_in = listed_ff;
      tmo_in    = tmo_ff;
      hit       = 1'b0;
      if (tok_ff) begin
         // scan token: expired sleeper check
         if (listed_ff && !diff[31]) begin
            tmo_in    = 1'b1;
            listed_in = 1'b0;
            if (state_ff == trrs_pkg::ST_BLOCKED || state_ff == trrs_pkg::ST_SLEEPING) begin
               state_in = trrs_pkg::ST_READY;
               hit      = 1'b1;
            end
         end
      end else if (sel) begin
         unique case (cmd.op)
            trrs_pkg::OP_ADD: begin
               prio_in   = cmd.prio;
               listed_in = 1'b0;
               tmo_in    = 1'b0;
               state_in  = trrs_pkg::ST_READY;
            end
            trrs_pkg::OP_READY: begin
               listed_in = 1'b0;
               state_in  = trrs_pkg::ST_READY;
            end
            trrs_pkg::OP_STATE: state_in = cmd.state;
            trrs_pkg::OP_SLEEP: begin
               state_in  = trrs_pkg::ST_SLEEPING;
               wake_in   = cmd.wake;
               listed_in = 1'b1;
               tmo_in    = 1'b0;
            end
            trrs_pkg::OP_EXIT: begin
               state_in  = trrs_pkg::ST_DEAD;
               listed_in = 1'b0;
               tmo_in    = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= (INDEX == 0) ? trrs_pkg::ST_RUNNING : trrs_pkg::ST_FREE;
         prio_ff   <= '0;
         listed_ff <= 1'b0;
         tmo_ff    <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prio_ff   <= prio_in;
         listed_ff <= listed_in;
         tmo_ff    <= tmo_in;
         tok_ff    <= tok_in;
      end
      wake_ff <= wake_in;
   end

   assign tok_out    = tok_ff;
   assign stat.state = state_ff;
   assign stat.prio  = prio_ff;

endmodule

// ===== hdl/trrs_queue.sv =====
// Circular FIFO run queue of task ids.
`timescale 1ns / 1ps
module trrs_queue #(
   parameter int DEPTH = trrs_pkg::TASK_COUNT_DEF,
   localparam int IW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [IW-1:0] push_data,
   input  logic          pop,
   output logic [IW-1:0] head_data,
   output logic          empty,
   output logic [CW-1:0] count
);

   logic [IW-1:0] slot_ff [DEPTH];
   logic [IW-1:0] head_ff;
   logic [CW-1:0] cnt_ff;
   logic [IW:0]   tail_sum, tail;
   logic          full, do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign tail_sum = (IW+1)'(head_ff) + (IW+1)'(cnt_ff);
   assign tail     = (tail_sum >= (IW+1)'(DEPTH)) ? tail_sum - (IW+1)'(DEPTH) : tail_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (do_pop) head_ff <= (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         cnt_ff <= cnt_ff + CW'(do_push) - CW'(do_pop);
      end
      if (do_push) slot_ff[tail[IW-1:0]] <= push_data;
   end

   assign head_data = slot_ff[head_ff];
   assign count     = cnt_ff;

endmodule

// ===== hdl/two_level_round_robin_task_scheduler.sv =====
// Top level: command sequencer, two run queues and the chain of task cells.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata[31:0]
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata[15:0]
//  csr     | in  | csr_valid/csr_ready    | csr_data[7:0] (quantum)
//
// Sequence: add, wake, ignored and refused commands go from execute to result;
// schedule and accepted sleep, block and exit pass a pick state in between; tick
// passes a scan state, where a token walks the cell chain, one task per cycle.
// Reset: synchronous; idle task running, queues empty, slice and quantum 10.
// Stalls: one result waits in the output register while the next command is
// taken; a command finishing while that register is full holds until it drains.
`timescale 1ns / 1ps
module two_level_round_robin_task_scheduler #(
   parameter int TASK_COUNT = trrs_pkg::TASK_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0], task_id[6:3], priority_req[10:7], duration[26:11], zero fill
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // current_task[3:0], switched[4], resched_pending[5], accepted[6],
   // woken_count[11:7], zero fill
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int IW = $clog2(TASK_COUNT);
   localparam int CW = $clog2(TASK_COUNT + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SCAN = 5'b00100,
      S_PICK = 5'b01000,
      S_RESP = 5'b10000
   } fsm_type;

   fsm_type state_ff, state_in;

   // captured command
   logic [2:0]  cmd_ff;
   logic [3:0]  tid_ff;
   logic [3:0]  prq_ff;
   logic [15:0] dur_ff;

   logic [IW-1:0] run_ff, run_in;
   logic [7:0]    slice_ff, slice_in;
   logic [7:0]    quantum_ff;
   logic [31:0]   tick_ff, tick_in;
   logic          resched_ff, resched_in;
   logic          acc_ff, acc_in;
   logic          sw_ff, sw_in;
   logic [4:0]    woken_ff, woken_in;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff;

   // cell chain
   trrs_pkg::cell_cmd_type  ccmd;
   trrs_pkg::cell_stat_type cstat [TASK_COUNT];
   logic [TASK_COUNT:0]     tok;
   logic                    tok_launch;
   logic [TASK_COUNT-1:0]   hits;
   logic [IW-1:0]           hit_id;

   // queues
   logic          hi_push, lo_push, hi_pop, lo_pop, hi_empty, lo_empty;
   logic [IW-1:0] hi_head, lo_head, push_id;
   logic [3:0]    push_prio;
   logic          push_en;
   logic [CW-1:0] hi_cnt, lo_cnt;

   logic          tid_ok;
   logic [IW-1:0] tidx;
   logic [3:0]    run_prio;
   logic [15:0]   dur_eff;
   logic [IW-1:0] next_id;
   logic          req_xfer, rsp_free;

   assign tid_ok   = (32'(tid_ff) < TASK_COUNT);
   assign tidx     = IW'(tid_ff);
   assign run_prio = cstat[run_ff].prio;
   assign dur_eff  = (dur_ff == '0) ? 16'd1 : dur_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign tok[0]   = tok_launch;

   // push routing: nonzero priority goes high
   assign hi_push = push_en && (push_prio != '0);
   assign lo_push = push_en && (push_prio == '0);

   always_comb begin
      hit_id = '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
         if (hits[i]) hit_id = IW'(i);
      end
   end

   always_comb begin
      state_in   = state_ff;
      run_in     = run_ff;
      slice_in   = slice_ff;
      tick_in    = tick_ff;
      resched_in = resched_ff;
      acc_in     = acc_ff;
      sw_in      = sw_ff;
      woken_in   = woken_ff;
      ccmd       = '{op: trrs_pkg::OP_NONE, id: '0, prio: '0, state: '0, wake: '0};
      push_en    = 1'b0;
      push_id    = '0;
      push_prio  = '0;
      hi_pop     = 1'b0;
      lo_pop     = 1'b0;
      next_id    = '0;
      tok_launch = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               acc_in   = 1'b1;
               sw_in    = 1'b0;
               woken_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            unique case (cmd_ff)
               trrs_pkg::CMD_ADD: begin
                  if (tid_ff != '0 && tid_ok &&
                      (cstat[tidx].state == trrs_pkg::ST_FREE ||
                       cstat[tidx].state == trrs_pkg::ST_DEAD)) begin
                     ccmd.op   = trrs_pkg::OP_ADD;
                     ccmd.id   = 8'(tidx);
                     ccmd.prio = prq_ff;
                     push_en   = 1'b1;
                     push_id   = tidx;
                     push_prio = prq_ff;
                  end else begin
                     acc_in = 1'b0;
                  end
               end
               trrs_pkg::CMD_WAKE: begin
                  if (tid_ok && (cstat[tidx].state == trrs_pkg::ST_BLOCKED ||
                                 cstat[tidx].state == trrs_pkg::ST_SLEEPING)) begin
                     ccmd.op   = trrs_pkg::OP_READY;
                     ccmd.id   = 8'(tidx);
                     push_en   = 1'b1;
                     push_id   = tidx;
                     push_prio = cstat[tidx].prio;
                     if (cstat[tidx].prio > run_prio || run_ff == '0) resched_in = 1'b1;
                  end else begin
                     acc_in = 1'b0;
                  end
               end
               trrs_pkg::CMD_TICK: begin
                  tick_in = tick_ff + 32'd1;
                  if (run_ff == '0) begin
                     if (!hi_empty || !lo_empty) resched_in = 1'b1;
                  end else begin
                     slice_in = (slice_ff != '0) ? slice_ff - 8'd1 : slice_ff;
                     if (slice_in == '0) resched_in = 1'b1;
                  end
                  tok_launch = 1'b1;   // launch the scan token into cell 0
                  state_in   = S_SCAN;
               end
               trrs_pkg::CMD_SCHED: begin
                  // requeue the running task before the pick; the idle task is only marked ready
                  if (cstat[run_ff].state == trrs_pkg::ST_RUNNING) begin
                     ccmd.op    = trrs_pkg::OP_STATE;
                     ccmd.id    = 8'(run_ff);
                     ccmd.state = trrs_pkg::ST_READY;
                     if (run_ff != '0) begin
                        push_en   = 1'b1;
                        push_id   = run_ff;
                        push_prio = run_prio;
                     end
                  end
                  state_in = S_PICK;
               end
               trrs_pkg::CMD_SLEEP, trrs_pkg::CMD_BLOCK, trrs_pkg::CMD_EXIT: begin
                  if (run_ff == '0) begin
                     acc_in = 1'b0;
                  end else begin
                     ccmd.id = 8'(run_ff);
                     if (cmd_ff == trrs_pkg::CMD_SLEEP) begin
                        ccmd.op   = trrs_pkg::OP_SLEEP;
                        ccmd.wake = tick_ff + 32'(dur_eff);
                     end else if (cmd_ff == trrs_pkg::CMD_BLOCK) begin
                        ccmd.op    = trrs_pkg::OP_STATE;
                        ccmd.state = trrs_pkg::ST_BLOCKED;
                     end else begin
                        ccmd.op = trrs_pkg::OP_EXIT;
                     end
                     state_in = S_PICK;
                  end
               end
               default: acc_in = 1'b0;
            endcase
         end
         S_SCAN: begin
            // the cell holding the token reports an expired sleeper
            if (|hits) begin
               push_en   = 1'b1;
               push_id   = hit_id;
               push_prio = cstat[hit_id].prio;
               woken_in  = woken_ff + 5'd1;
               if (cstat[hit_id].prio > run_prio || run_ff == '0) resched_in = 1'b1;
            end
            if (tok[TASK_COUNT]) state_in = S_RESP;
         end
         S_PICK: begin
            priority if (!hi_empty) begin
               next_id = hi_head;
               hi_pop  = 1'b1;
            end else if (!lo_empty) begin
               next_id = lo_head;
               lo_pop  = 1'b1;
            end else begin
               next_id = '0;
            end
            ccmd.op    = trrs_pkg::OP_STATE;
            ccmd.id    = 8'(next_id);
            ccmd.state = trrs_pkg::ST_RUNNING;
            resched_in = 1'b0;
            slice_in   = quantum_ff;
            sw_in      = (next_id != run_ff);
            run_in     = next_id;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_ff       <= '0;
         slice_ff     <= trrs_pkg::SLICE_RESET;
         quantum_ff   <= trrs_pkg::SLICE_RESET;
         tick_ff      <= '0;
         resched_ff   <= 1'b0;
         acc_ff       <= 1'b0;
         sw_ff        <= 1'b0;
         woken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         run_ff     <= run_in;
         slice_ff   <= slice_in;
         tick_ff    <= tick_in;
         resched_ff <= resched_in;
         acc_ff     <= acc_in;
         sw_ff      <= sw_in;
         woken_ff   <= woken_in;
         if (csr_valid) quantum_ff <= csr_data;
         if (state_ff == S_RESP && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (req_xfer) begin
         cmd_ff <= req_tdata[2:0];
         tid_ff <= req_tdata[6:3];
         prq_ff <= req_tdata[10:7];
         dur_ff <= req_tdata[26:11];
      end
      if (state_ff == S_RESP && rsp_free)
         rsp_data_ff <= {4'b0, woken_ff, acc_ff, resched_ff, sw_ff, 4'(run_ff)};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the chain: scan token hops one cell per cycle
   for (genvar g = 0; g < TASK_COUNT; g++) begin : g_cell
      trrs_cell #(.INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (ccmd),
         .tick    (tick_ff),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1]),
         .stat    (cstat[g]),
         .hit     (hits[g])
      );
   end

   trrs_queue #(.DEPTH(TASK_COUNT)) u_hi_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hi_push),
      .push_data (push_id),
      .pop       (hi_pop),
      .head_data (hi_head),
      .empty     (hi_empty),
      .count     (hi_cnt)
   );

   trrs_queue #(.DEPTH(TASK_COUNT)) u_lo_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (lo_push),
      .push_data (push_id),
      .pop       (lo_pop),
      .head_data (lo_head),
      .empty     (lo_empty),
      .count     (lo_cnt)
   );

   // between commands the running task's cell says it runs
   a_run_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (cstat[run_ff].state == trrs_pkg::ST_RUNNING))
      else $error("running task cell not in running state");

   // at most one cell holds the scan token
   a_tok_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok[TASK_COUNT:1]))
      else $error("scan token duplicated");

   // the two run queues together hold no more entries than there are tasks
   a_queue_total: assert property (@(posedge clock) disable iff (reset)
      ((CW+1)'(hi_cnt) + (CW+1)'(lo_cnt)) <= (CW+1)'(TASK_COUNT))
      else $error("run queues hold more entries than tasks");

   // a pick always leaves the reschedule flag clear
   a_pick_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PICK) |=> !resched_ff)
      else $error("reschedule flag survived a pick");

endmodule

// ===== test/tb_two_level_round_robin_task_scheduler.sv =====
// Testbench for the two-level round-robin task scheduler: directed table, then random commands.
`timescale 1ns / 1ps
module tb_two_level_round_robin_task_scheduler;

   localparam int NTASK = trrs_pkg::TASK_COUNT_DEF;
   localparam int DRAIN_CYCLES = 40;     // longer than a tick command takes, scan of all NTASK cells included
   localparam int STALL_LIMIT = 4000;    // cycles with no transfer on any channel
   localparam logic [2:0] CMD_UNDEF = 3'd7;

   // same bit order as rsp_tdata[11:0]
   typedef struct packed {
      logic [4:0] woken;
      logic       acc;
      logic       resched;
      logic       sw;
      logic [3:0] cur;
   } sched_result_type;

   typedef struct {
      logic [2:0]       cmd;
      logic [3:0]       tid;
      logic [3:0]       prio;
      logic [15:0]      dur;
      bit               typed;
      sched_result_type res;
   } stim_row_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_data;

   two_level_round_robin_task_scheduler dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // scheduler mirror
   trrs_pkg::tstate_type task_st[NTASK];
   logic [3:0]    task_pri[NTASK];
   logic [31:0]   wake_at[NTASK];
   logic [1:0]    sleep_fl[NTASK];
   int            high_rq[$];
   int            norm_rq[$];
   int            running;
   logic [7:0]    slice_left;
   bit            resched;
   logic [31:0]   ticks;
   logic [7:0]    quantum;

   sched_result_type pending_results[$];
   bit               typed_next;
   sched_result_type typed_res;

   int  errors = 0;
   int  n_sent = 0, n_checked = 0, n_ticks = 0, n_switches = 0, n_woken = 0;
   int  idle_count = 0;
   bit  calm = 0;          // no idling on either side while set
   bit  hold_rsp = 0;      // asks the receiver for one long hold-off

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void run_queue_put(int t);
      if (task_pri[t] > 0) begin
         if (high_rq.size() < NTASK) high_rq.push_back(t);
      end else begin
         if (norm_rq.size() < NTASK) norm_rq.push_back(t);
      end
   endfunction

   function automatic bit ready_task(int t);
      if (task_st[t] != trrs_pkg::ST_BLOCKED && task_st[t] != trrs_pkg::ST_SLEEPING) return 0;
      sleep_fl[t][0] = 1'b0;
      task_st[t] = trrs_pkg::ST_READY;
      run_queue_put(t);
      if (task_pri[t] > task_pri[running] || running == 0) resched = 1;
      return 1;
   endfunction

   function automatic bit switch_task();
      int prev;
      int nxt;
      prev = running;
      if (task_st[prev] == trrs_pkg::ST_RUNNING) begin
         task_st[prev] = trrs_pkg::ST_READY;
         if (prev != 0) run_queue_put(prev);
      end
      if (high_rq.size() > 0) nxt = high_rq.pop_front();
      else if (norm_rq.size() > 0) nxt = norm_rq.pop_front();
      else nxt = 0;
      task_st[nxt] = trrs_pkg::ST_RUNNING;
      resched = 0;
      slice_left = quantum;
      running = nxt;
      return nxt != prev;
   endfunction

   function automatic void mirror_reset();
      foreach (task_st[i]) begin
         task_st[i] = trrs_pkg::ST_FREE;
         task_pri[i] = '0;
         wake_at[i] = '0;
         sleep_fl[i] = '0;
      end
      task_st[0] = trrs_pkg::ST_RUNNING;
      high_rq.delete();
      norm_rq.delete();
      running = 0;
      slice_left = trrs_pkg::SLICE_RESET;
      resched = 0;
      ticks = '0;
      quantum = trrs_pkg::SLICE_RESET;
   endfunction

   // apply one command to the mirror and return what the block must report
   function automatic sched_result_type schedule_step(logic [31:0] d);
      logic [2:0]       cmd;
      int               tid;
      logic [3:0]       pri;
      logic [15:0]      dur;
      logic [31:0]      age;
      sched_result_type r;
      cmd = d[2:0];
      tid = d[6:3];
      pri = d[10:7];
      dur = d[26:11];
      r = '0;
      r.acc = 1;
      case (cmd)
         trrs_pkg::CMD_ADD: begin
            if (tid == 0 || (task_st[tid] != trrs_pkg::ST_FREE &&
                             task_st[tid] != trrs_pkg::ST_DEAD)) begin
               r.acc = 0;
            end else begin
               task_pri[tid] = pri;
               sleep_fl[tid] = '0;
               task_st[tid] = trrs_pkg::ST_READY;
               run_queue_put(tid);
            end
         end
         trrs_pkg::CMD_WAKE: r.acc = ready_task(tid);
         trrs_pkg::CMD_TICK: begin
            ticks++;
            if (running == 0) begin
               if (high_rq.size() > 0 || norm_rq.size() > 0) resched = 1;
            end else begin
               if (slice_left > 0) slice_left--;
               if (slice_left == 0) resched = 1;
            end
            for (int i = 0; i < NTASK; i++) begin
               age = ticks - wake_at[i];
               if (sleep_fl[i][0] && !age[31]) begin
                  sleep_fl[i][1] = 1'b1;
                  if (ready_task(i)) r.woken++;
                  else sleep_fl[i][0] = 1'b0;
               end
            end
         end
         trrs_pkg::CMD_SCHED: r.sw = switch_task();
         trrs_pkg::CMD_SLEEP, trrs_pkg::CMD_BLOCK, trrs_pkg::CMD_EXIT: begin
            if (running == 0) begin
               r.acc = 0;
            end else begin
               if (cmd == trrs_pkg::CMD_SLEEP) begin
                  task_st[running] = trrs_pkg::ST_SLEEPING;
                  wake_at[running] = ticks + ((dur == 0) ? 32'd1 : 32'(dur));
                  sleep_fl[running] = 2'b01;
               end else if (cmd == trrs_pkg::CMD_BLOCK) begin
                  task_st[running] = trrs_pkg::ST_BLOCKED;
               end else begin
                  task_st[running] = trrs_pkg::ST_DEAD;
                  sleep_fl[running] = '0;
               end
               r.sw = switch_task();
            end
         end
         default: r.acc = 0;
      endcase
      r.cur = running[3:0];
      r.resched = resched;
      return r;
   endfunction

   // command transfers feed the mirror
   always @(posedge clock) begin
      sched_result_type r;
      if (!reset && req_tvalid && req_tready) begin
         r = schedule_step(req_tdata);
         if (req_tdata[2:0] == trrs_pkg::CMD_TICK) n_ticks++;
         pending_results.push_back(typed_next ? typed_res : r);
      end
   end

   // result transfers are checked against the oldest expectation
   always @(posedge clock) begin
      sched_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[11:0];
         if (rsp_tdata[15:12] != '0) report($sformatf("fill bits %h", rsp_tdata[15:12]));
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (got.sw) n_switches++;
            n_woken += got.woken;
            if (got.cur != want.cur)
               report($sformatf("current_task %0d, want %0d", got.cur, want.cur));
            if (got.sw != want.sw)
               report($sformatf("switched %0d, want %0d", got.sw, want.sw));
            if (got.resched != want.resched)
               report($sformatf("resched_pending %0d, want %0d", got.resched, want.resched));
            if (got.acc != want.acc)
               report($sformatf("accepted %0d, want %0d", got.acc, want.acc));
            if (got.woken != want.woken)
               report($sformatf("woken_count %0d, want %0d", got.woken, want.woken));
         end
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("** two_level_round_robin_task_scheduler: FAILED **");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] tid,
                           input logic [3:0] pri, input logic [15:0] dur);
      while (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, dur, pri, tid, cmd};
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      typed_next <= 0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [7:0] q);
      csr_valid <= 1;
      csr_data <= q;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      quantum = q;
   endtask

   task automatic random_cmd();
      int          sel;
      logic [2:0]  cmd;
      logic [3:0]  pri;
      logic [15:0] dur;
      sel = $urandom_range(99);
      if (sel < 25) cmd = trrs_pkg::CMD_TICK;
      else if (sel < 40) cmd = trrs_pkg::CMD_SCHED;
      else if (sel < 55) cmd = trrs_pkg::CMD_ADD;
      else if (sel < 70) cmd = trrs_pkg::CMD_WAKE;
      else if (sel < 80) cmd = trrs_pkg::CMD_SLEEP;
      else if (sel < 88) cmd = trrs_pkg::CMD_BLOCK;
      else if (sel < 97) cmd = trrs_pkg::CMD_EXIT;
      else cmd = CMD_UNDEF;
      pri = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15));
      dur = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8));
      send_cmd(cmd, 4'($urandom_range(15)), pri, dur);
   endtask

   stim_row_type plan[$];

   function automatic void row(logic [2:0] c, logic [3:0] t, logic [3:0] p, logic [15:0] d,
                               bit ty, logic [3:0] cur, bit sw, bit rs, bit acc, logic [4:0] w);
      stim_row_type s;
      s.cmd = c; s.tid = t; s.prio = p; s.dur = d; s.typed = ty;
      s.res = {w, acc, rs, sw, cur};
      plan.push_back(s);
   endfunction

   initial begin
      logic [7:0] qv[4];
      reset = 1;
      req_tvalid = 0; req_tdata = '0;
      csr_valid = 0; csr_data = '0;
      typed_next = 0;
      mirror_reset();
      repeat (12) @(posedge clock);
      reset <= 0;

      // directed walk through refusals, sleep expiry, wake and exit
      row(trrs_pkg::CMD_WAKE,  4'd5,  4'd0,  16'd0,     1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_SLEEP, 4'd0,  4'd0,  16'd3,     1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_BLOCK, 4'd0,  4'd0,  16'd0,     1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_EXIT,  4'd0,  4'd0,  16'd0,     1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_ADD,   4'd0,  4'd7,  16'd0,     1, 4'd0,  0, 0, 0, 0);
      row(CMD_UNDEF,           4'd15, 4'd15, 16'hFFFF,  1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_SCHED, 4'd0,  4'd0,  16'd0,     1, 4'd0,  0, 0, 1, 0);
      row(trrs_pkg::CMD_ADD,   4'd15, 4'd15, 16'd0,     1, 4'd0,  0, 0, 1, 0);
      row(trrs_pkg::CMD_ADD,   4'd1,  4'd0,  16'd0,     1, 4'd0,  0, 0, 1, 0);
      row(trrs_pkg::CMD_ADD,   4'd15, 4'd3,  16'd0,     1, 4'd0,  0, 0, 0, 0);
      row(trrs_pkg::CMD_TICK,  4'd0,  4'd0,  16'd0,     1, 4'd0,  0, 1, 1, 0);
      row(trrs_pkg::CMD_SCHED, 4'd0,  4'd0,  16'd0,     1, 4'd15, 1, 0, 1, 0);
      row(trrs_pkg::CMD_SLEEP, 4'd0,  4'd0,  16'd0,     1, 4'd1,  1, 0, 1, 0);  // zero sleeps a tick
      row(trrs_pkg::CMD_TICK,  4'd0,  4'd0,  16'd0,     1, 4'd1,  0, 1, 1, 1);
      row(trrs_pkg::CMD_SCHED, 4'd0,  4'd0,  16'd0,     1, 4'd15, 1, 0, 1, 0);
      row(trrs_pkg::CMD_BLOCK, 4'd0,  4'd0,  16'd0,     1, 4'd1,  1, 0, 1, 0);
      row(trrs_pkg::CMD_WAKE,  4'd15, 4'd0,  16'd0,     1, 4'd1,  0, 1, 1, 0);
      row(trrs_pkg::CMD_WAKE,  4'd15, 4'd0,  16'd0,     1, 4'd1,  0, 1, 0, 0);
      row(trrs_pkg::CMD_EXIT,  4'd0,  4'd0,  16'd0,     1, 4'd15, 1, 0, 1, 0);
      row(trrs_pkg::CMD_ADD,   4'd1,  4'd3,  16'd0,     1, 4'd15, 0, 0, 1, 0);  // dead task re-added
      row(trrs_pkg::CMD_SLEEP, 4'd0,  4'd0,  16'hFFFF,  1, 4'd1,  1, 0, 1, 0);
      row(trrs_pkg::CMD_ADD,   4'd14, 4'd0,  16'hFFFF,  0, '0, 0, 0, 0, 0);
      row(trrs_pkg::CMD_TICK,  4'd15, 4'd15, 16'hAAAA,  0, '0, 0, 0, 0, 0);
      row(trrs_pkg::CMD_WAKE,  4'd1,  4'd0,  16'h5555,  0, '0, 0, 0, 0, 0);
      row(trrs_pkg::CMD_SCHED, 4'd0,  4'd0,  16'd0,     0, '0, 0, 0, 0, 0);
      foreach (plan[i]) begin
         // travels with the command, so the monitor sees the row that was offered
         typed_next <= plan[i].typed;
         typed_res <= plan[i].res;
         send_cmd(plan[i].cmd, plan[i].tid, plan[i].prio, plan[i].dur);
      end
      drain();

      // random phases, one quantum setting each: both extremes, a random one, reset value
      qv[0] = 8'd1; qv[1] = 8'd255; qv[2] = 8'($urandom_range(2, 254));
      qv[3] = trrs_pkg::SLICE_RESET;
      for (int ph = 0; ph < 4; ph++) begin
         write_quantum(qv[ph]);
         for (int k = 0; k < 345; k++) begin
            calm = (k >= 100 && k < 160);
            if (ph == 1 && k == 200) hold_rsp = 1;   // block backs up behind a stalled sink
            random_cmd();
         end
         calm = 0;
         drain();
      end

      $display("covered %0d commands (%0d ticks), %0d results checked", n_sent, n_ticks,
               n_checked);
      $display("saw %0d task switches and %0d timed-out sleepers woken", n_switches, n_woken);
      if (errors == 0) begin
         $display("** two_level_round_robin_task_scheduler: PASSED **");
      end else begin
         $display("** two_level_round_robin_task_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
